// ===== hdl/emop_pkg.sv =====
`timescale 1ns / 1ps

package emop_pkg;

    localparam int CORDIC_STAGES_DEF = 16;

    // Field widths
    localparam int POS_W  = 20;
    localparam int VEL_W  = 16;
    localparam int RATE_W = 16;
    localparam int DT_W   = 16;

    // Stream word widths, whole bytes
    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 72;

    // Internal widths
    localparam int XY_W   = 32;   // CORDIC x and y, Q30
    localparam int Z_W    = 33;   // residual angle, 2^-30 rad
    localparam int ANG_W  = 34;   // yaw_rate * time_step * 4
    localparam int WRAP_W = 36;   // headroom for the two-pi wrap
    localparam int MVL_W  = 33;   // (vel_long - ego_speed) * time_step
    localparam int MVT_W  = 32;   // vel_lat * time_step

    localparam logic signed [XY_W-1:0]   GAIN_Q30    = 32'sd652032874;
    localparam logic signed [WRAP_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [WRAP_W-1:0] NEG_PI_Q30  = -36'sd3373259426;
    localparam logic signed [WRAP_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [WRAP_W-1:0] NEG_HALF_PI_Q30 = -36'sd1686629713;
    localparam logic signed [WRAP_W-1:0] TWO_PI_Q30  = 36'sd6746518852;

    typedef struct packed {
        logic signed [POS_W-1:0]  pos_long;
        logic signed [POS_W-1:0]  pos_lat;
        logic signed [VEL_W-1:0]  vel_long;
        logic signed [VEL_W-1:0]  vel_lat;
        logic signed [VEL_W-1:0]  ego_speed;
        logic signed [RATE_W-1:0] yaw_rate;
        logic        [DT_W-1:0]   time_step;
    } obj_t;

    // Object data that rides along the rotator
    typedef struct packed {
        logic signed [POS_W-1:0] pos_long;
        logic signed [POS_W-1:0] pos_lat;
        logic signed [VEL_W-1:0] vel_long;
        logic signed [VEL_W-1:0] vel_lat;
        logic signed [MVL_W-1:0] move_long;
        logic signed [MVT_W-1:0] move_lat;
        logic                    flip;
    } carry_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } rot_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pred_pos_long;
        logic signed [POS_W-1:0] pred_pos_lat;
        logic signed [VEL_W-1:0] pred_vel_long;
        logic signed [VEL_W-1:0] pred_vel_lat;
    } result_t;

    // arctan(2^-idx) in units of 2^-30 rad, rounded to nearest.
    // From idx 11 on, the cubic term is below half a unit.
    function automatic logic signed [Z_W-1:0] atan_q30(input int idx);
        logic signed [Z_W-1:0] val;
        case (idx)
            0:       val = 33'sd843314857;
            1:       val = 33'sd497837829;
            2:       val = 33'sd263043837;
            3:       val = 33'sd133525159;
            4:       val = 33'sd67021687;
            5:       val = 33'sd33543516;
            6:       val = 33'sd16775851;
            7:       val = 33'sd8388437;
            8:       val = 33'sd4194283;
            9:       val = 33'sd2097149;
            10:      val = 33'sd1048576;
            default: val = (idx <= 30) ? Z_W'(64'sd1 <<< (30 - idx)) : 33'sd1;
        endcase
        return val;
    endfunction

endpackage

// ===== hdl/emop_front.sv =====
`timescale 1ns / 1ps

module emop_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  emop_pkg::obj_t  in_obj,
    output logic            out_valid,
    output emop_pkg::rot_t  out_rot,
    output emop_pkg::carry_t out_carry
);
    import emop_pkg::*;

    // Stage 1: angle and travel products
    logic                    v1_reg;
    logic signed [ANG_W-1:0] ang1_reg, ang1_next;
    carry_t                  carry1_reg, carry1_next;

    logic signed [RATE_W+DT_W:0]  ang_prod;
    logic signed [VEL_W:0]        dvel;
    logic signed [VEL_W+DT_W+1:0] mvl_prod;
    logic signed [VEL_W+DT_W:0]   mvt_prod;

    always_comb begin
        ang_prod = $signed(in_obj.yaw_rate) * $signed({1'b0, in_obj.time_step});
        dvel     = $signed({in_obj.vel_long[VEL_W-1], in_obj.vel_long})
                 - $signed({in_obj.ego_speed[VEL_W-1], in_obj.ego_speed});
        mvl_prod = dvel * $signed({1'b0, in_obj.time_step});
        mvt_prod = $signed(in_obj.vel_lat) * $signed({1'b0, in_obj.time_step});

        // Product fits 32 bits; times four puts it in 2^-30 rad.
        ang1_next = {ang_prod[ANG_W-3:0], 2'b00};

        carry1_next.pos_long  = in_obj.pos_long;
        carry1_next.pos_lat   = in_obj.pos_lat;
        carry1_next.vel_long  = in_obj.vel_long;
        carry1_next.vel_lat   = in_obj.vel_lat;
        carry1_next.move_long = mvl_prod[MVL_W-1:0];
        carry1_next.move_lat  = mvt_prod[MVT_W-1:0];
        carry1_next.flip      = 1'b0;
    end

    // Stage 2: bring the angle into [-pi, pi]. The largest angle is just
    // under eight radians, so one correction always suffices.
    logic                    v2_reg;
    logic signed [Z_W-1:0]   ang2_reg, ang2_next;
    carry_t                  carry2_reg;
    logic signed [WRAP_W-1:0] wide1, wrapped;

    always_comb begin
        wide1 = WRAP_W'(ang1_reg);
        if (wide1 > PI_Q30) begin
            wrapped = wide1 - TWO_PI_Q30;
        end else if (wide1 < NEG_PI_Q30) begin
            wrapped = wide1 + TWO_PI_Q30;
        end else begin
            wrapped = wide1;
        end
        ang2_next = wrapped[Z_W-1:0];
    end

    // Stage 3: fold into [-pi/2, pi/2]; the sign of cos and sin is flipped
    // afterwards.
    logic                    v3_reg;
    logic signed [Z_W-1:0]   z3_reg, z3_next;
    carry_t                  carry3_reg, carry3_next;
    logic signed [WRAP_W-1:0] wide2, folded;

    always_comb begin
        wide2       = WRAP_W'(ang2_reg);
        carry3_next = carry2_reg;
        if (wide2 > HALF_PI_Q30) begin
            folded           = wide2 - PI_Q30;
            carry3_next.flip = 1'b1;
        end else if (wide2 < NEG_HALF_PI_Q30) begin
            folded           = wide2 + PI_Q30;
            carry3_next.flip = 1'b1;
        end else begin
            folded           = wide2;
        end
        z3_next = folded[Z_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ang1_reg   <= ang1_next;
            carry1_reg <= carry1_next;
            ang2_reg   <= ang2_next;
            carry2_reg <= carry1_reg;
            z3_reg     <= z3_next;
            carry3_reg <= carry3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_rot   = '{x: GAIN_Q30, y: '0, z: z3_reg};
    assign out_carry = carry3_reg;

endmodule

// ===== hdl/emop_cordic_cell.sv =====
`timescale 1ns / 1ps

module emop_cordic_cell #(
    parameter int STAGE_IDX = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  emop_pkg::rot_t   in_rot,
    input  emop_pkg::carry_t in_carry,
    output logic             out_valid,
    output emop_pkg::rot_t   out_rot,
    output emop_pkg::carry_t out_carry
);
    import emop_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = atan_q30(STAGE_IDX);

    logic   valid_reg;
    rot_t   rot_reg, rot_next;
    carry_t carry_reg;

    logic signed [XY_W-1:0] x_sh, y_sh;

    // One micro-rotation; the shifts floor toward minus infinity.
    always_comb begin
        x_sh = $signed(in_rot.x) >>> STAGE_IDX;
        y_sh = $signed(in_rot.y) >>> STAGE_IDX;
        if (!in_rot.z[Z_W-1]) begin
            rot_next.x = in_rot.x - y_sh;
            rot_next.y = in_rot.y + x_sh;
            rot_next.z = in_rot.z - ATAN;
        end else begin
            rot_next.x = in_rot.x + y_sh;
            rot_next.y = in_rot.y - x_sh;
            rot_next.z = in_rot.z + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rot_reg   <= rot_next;
            carry_reg <= in_carry;
        end
    end

    assign out_valid = valid_reg;
    assign out_rot   = rot_reg;
    assign out_carry = carry_reg;

endmodule

// ===== hdl/emop_back.sv =====
`timescale 1ns / 1ps

module emop_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  emop_pkg::rot_t    in_rot,
    input  emop_pkg::carry_t  in_carry,
    output logic              out_valid,
    output emop_pkg::result_t out_result
);
    import emop_pkg::*;

    localparam int PP_W = POS_W + XY_W;   // position products, 2^-40 m
    localparam int VP_W = VEL_W + XY_W;   // velocity products, 2^-38 m/s
    localparam int PS_W = PP_W + 2;
    localparam int VS_W = VP_W + 1;
    localparam int FRAC = 30;
    localparam int PR_W = PS_W + 1 - FRAC;
    localparam int VR_W = VS_W + 1 - FRAC;
    localparam int TRAVEL_SH = 17;        // speed * interval is 2^-23 m

    localparam logic signed [PS_W:0]   P_HALF = (PS_W + 1)'(2 ** (FRAC - 1));
    localparam logic signed [VS_W:0]   V_HALF = (VS_W + 1)'(2 ** (FRAC - 1));
    localparam logic signed [PR_W-1:0] P_HI   = PR_W'(2 ** (POS_W - 1) - 1);
    localparam logic signed [PR_W-1:0] P_LO   = -P_HI - 1;
    localparam logic signed [VR_W-1:0] V_HI   = VR_W'(2 ** (VEL_W - 1) - 1);
    localparam logic signed [VR_W-1:0] V_LO   = -V_HI - 1;

    function automatic logic signed [POS_W-1:0] round_sat_pos(
        input logic signed [PS_W-1:0] v
    );
        logic signed [PS_W:0]   t;
        logic signed [PR_W-1:0] r;
        logic signed [PR_W-1:0] q;
        t = $signed({v[PS_W-1], v}) + P_HALF;
        r = t[PS_W:FRAC];
        if (r > P_HI) begin
            q = P_HI;
        end else if (r < P_LO) begin
            q = P_LO;
        end else begin
            q = r;
        end
        return q[POS_W-1:0];
    endfunction

    function automatic logic signed [VEL_W-1:0] round_sat_vel(
        input logic signed [VS_W-1:0] v
    );
        logic signed [VS_W:0]   t;
        logic signed [VR_W-1:0] r;
        logic signed [VR_W-1:0] q;
        t = $signed({v[VS_W-1], v}) + V_HALF;
        r = t[VS_W:FRAC];
        if (r > V_HI) begin
            q = V_HI;
        end else if (r < V_LO) begin
            q = V_LO;
        end else begin
            q = r;
        end
        return q[VEL_W-1:0];
    endfunction

    // Stage 1: cos and sin with the fold applied
    logic                   v1_reg;
    logic signed [XY_W-1:0] cos1_reg, sin1_reg;
    carry_t                 carry1_reg;

    // Stage 2: products
    logic                   v2_reg;
    logic signed [PP_W-1:0] plc_reg, pts_reg, ptc_reg, pls_reg;
    logic signed [VP_W-1:0] vlc_reg, vts_reg, vtc_reg, vls_reg;
    carry_t                 carry2_reg;

    // Stage 3: sums
    logic                   v3_reg;
    logic signed [PS_W-1:0] sum_long_reg, sum_lat_reg, sum_long_next, sum_lat_next;
    logic signed [VS_W-1:0] vsum_long_reg, vsum_lat_reg, vsum_long_next, vsum_lat_next;

    // Stage 4: rounded and saturated result
    logic    v4_reg;
    result_t res4_reg, res4_next;

    always_comb begin
        sum_long_next = PS_W'(plc_reg) + PS_W'(pts_reg)
                      + (PS_W'(carry2_reg.move_long) <<< TRAVEL_SH);
        sum_lat_next  = PS_W'(ptc_reg) - PS_W'(pls_reg)
                      + (PS_W'(carry2_reg.move_lat) <<< TRAVEL_SH);
        vsum_long_next = VS_W'(vlc_reg) + VS_W'(vts_reg);
        vsum_lat_next  = VS_W'(vtc_reg) - VS_W'(vls_reg);

        res4_next.pred_pos_long = round_sat_pos(sum_long_reg);
        res4_next.pred_pos_lat  = round_sat_pos(sum_lat_reg);
        res4_next.pred_vel_long = round_sat_vel(vsum_long_reg);
        res4_next.pred_vel_lat  = round_sat_vel(vsum_lat_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos1_reg   <= in_carry.flip ? -in_rot.x : in_rot.x;
            sin1_reg   <= in_carry.flip ? -in_rot.y : in_rot.y;
            carry1_reg <= in_carry;

            plc_reg    <= $signed(carry1_reg.pos_long) * cos1_reg;
            pts_reg    <= $signed(carry1_reg.pos_lat)  * sin1_reg;
            ptc_reg    <= $signed(carry1_reg.pos_lat)  * cos1_reg;
            pls_reg    <= $signed(carry1_reg.pos_long) * sin1_reg;
            vlc_reg    <= $signed(carry1_reg.vel_long) * cos1_reg;
            vts_reg    <= $signed(carry1_reg.vel_lat)  * sin1_reg;
            vtc_reg    <= $signed(carry1_reg.vel_lat)  * cos1_reg;
            vls_reg    <= $signed(carry1_reg.vel_long) * sin1_reg;
            carry2_reg <= carry1_reg;

            sum_long_reg  <= sum_long_next;
            sum_lat_reg   <= sum_lat_next;
            vsum_long_reg <= vsum_long_next;
            vsum_lat_reg  <= vsum_lat_next;

            res4_reg <= res4_next;
        end
    end

    assign out_valid  = v4_reg;
    assign out_result = res4_reg;

endmodule

// ===== hdl/ego_motion_object_predict_unit.sv =====
`timescale 1ns / 1ps

// Ego-motion compensated constant-velocity prediction of tracked objects.
// Each input word on the s_ channel carries one object's position and
// velocity together with the host speed, yaw rate and prediction interval.
// Each word produces exactly one result word on the m_ channel: the object's
// predicted position and rotated velocity in the new host frame, saturated.
// Throughput is one word per cycle unless the skid register is full; words
// are independent and the rotator is a row of CORDIC_STAGES pipelined cells,
// one micro-rotation each. From the accepting edge to m_tvalid a word passes
// the angle preparation stages, the cell row, the fold, multiply, sum and
// round stages of the back end, and the output register.
// When m_tready is low, the output register holds its word and one more word
// goes to a skid register; while that skid register is full the whole
// pipeline holds and s_tready is low. s_tready is driven from a register.
// Reset (aresetn low at a clock edge) empties the pipeline and both output
// registers; no word is lost or duplicated across a stall.

module ego_motion_object_predict_unit #(
    parameter int CORDIC_STAGES = emop_pkg::CORDIC_STAGES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pos_long[19:0], pos_lat[39:20], vel_long[55:40], vel_lat[71:56],
    // ego_speed[87:72], yaw_rate[103:88], time_step[119:104]
    input  logic [emop_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // pred_pos_long[19:0], pred_pos_lat[39:20], pred_vel_long[55:40],
    // pred_vel_lat[71:56]
    output logic [emop_pkg::M_TDATA_W-1:0]   m_tdata
);
    import emop_pkg::*;

    // The pipeline advances whenever the skid register is free.
    logic pipe_en;

    obj_t in_obj;

    always_comb begin
        in_obj.pos_long  = s_tdata[19:0];
        in_obj.pos_lat   = s_tdata[39:20];
        in_obj.vel_long  = s_tdata[55:40];
        in_obj.vel_lat   = s_tdata[71:56];
        in_obj.ego_speed = s_tdata[87:72];
        in_obj.yaw_rate  = s_tdata[103:88];
        in_obj.time_step = s_tdata[119:104];
    end

    logic   chain_valid [CORDIC_STAGES+1];
    rot_t   chain_rot   [CORDIC_STAGES+1];
    carry_t chain_carry [CORDIC_STAGES+1];

    emop_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s_tvalid),
        .in_obj    (in_obj),
        .out_valid (chain_valid[0]),
        .out_rot   (chain_rot[0]),
        .out_carry (chain_carry[0])
    );

    // Cell i rotates by arctan(2^-i) and hands its registered x, y, z and the
    // object data on to cell i+1.
    for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_cell
        emop_cordic_cell #(
            .STAGE_IDX (gi)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (chain_valid[gi]),
            .in_rot    (chain_rot[gi]),
            .in_carry  (chain_carry[gi]),
            .out_valid (chain_valid[gi+1]),
            .out_rot   (chain_rot[gi+1]),
            .out_carry (chain_carry[gi+1])
        );
    end

    logic    pipe_valid;
    result_t pipe_result;

    emop_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (pipe_en),
        .in_valid   (chain_valid[CORDIC_STAGES]),
        .in_rot     (chain_rot[CORDIC_STAGES]),
        .in_carry   (chain_carry[CORDIC_STAGES]),
        .out_valid  (pipe_valid),
        .out_result (pipe_result)
    );

    // Output register with a skid register behind it.
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg,  out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg,  skid_data_next;
    logic    pipe_exit;

    assign pipe_en   = !skid_valid_reg;
    assign pipe_exit = pipe_en && pipe_valid;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready) begin
            // The output register is free or being emptied this cycle.
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next  = pipe_exit;
                out_data_next   = pipe_result;
            end
        end else if (pipe_exit) begin
            // Output is stalled; park the word leaving the pipeline.
            skid_valid_next = 1'b1;
            skid_data_next  = pipe_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign s_tready = pipe_en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.pred_vel_lat, out_data_reg.pred_vel_long,
                       out_data_reg.pred_pos_lat, out_data_reg.pred_pos_long};

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import emop_pkg::*;

    // The block under test runs at its default rotator length, so the
    // predictor uses the same number of micro-rotations.
    localparam int STAGES         = CORDIC_STAGES_DEF;
    localparam int LATENCY        = STAGES + 7;
    localparam int LIMIT_CYCLES   = 400000;
    localparam int RANDOM_OBJECTS = 650;

    // Angle constants in units of 2^-30 rad and the rotator gain in Q30.
    localparam longint ROT_GAIN     = 64'sd652032874;
    localparam longint ANG_ATAN_ONE = 64'sd843314857;
    localparam longint ANG_PI       = 64'sd3373259426;
    localparam longint ANG_HALF_PI  = 64'sd1686629713;
    localparam longint ANG_TWO_PI   = 64'sd6746518852;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Arctangents of 2^-i, predictions waiting for their result words, and
    // the run's bookkeeping.
    longint  atan_table[32];
    result_t pending_predictions[$];
    int      objects_sent    = 0;
    int      results_checked = 0;
    int      mismatch_count  = 0;
    bit      quiet_phase     = 1'b0;

    always #4 aclk = ~aclk;

    ego_motion_object_predict_unit #(
        .CORDIC_STAGES(STAGES)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Arctangent entries past 0 come from the odd power series at 2^-60 and
    // rounded to the nearest unit of 2^-30 rad, independent of the RTL table.
    initial begin
        longint acc;
        int     i;
        int     k;
        int     odd;
        int     e;
        atan_table[0] = ANG_ATAN_ONE;
        for (i = 1; i < 32; i++) begin
            acc = 0;
            k   = 0;
            odd = 1;
            e   = i;
            while (e <= 60) begin
                if (k % 2 == 1) begin
                    acc = acc - longint'((64'd1 << (60 - e)) / odd);
                end else begin
                    acc = acc + longint'((64'd1 << (60 - e)) / odd);
                end
                k   = k + 1;
                odd = 2 * k + 1;
                e   = i * odd;
            end
            atan_table[i] = (acc + (64'sd1 <<< 29)) >>> 30;
        end
    end

    // Rounds a sum held in units of 2^-30 of the output unit: half a unit is
    // added, the sum is floored, and the result saturates to a w-bit field.
    function automatic longint round_clamp(input longint v, input int w);
        longint q;
        longint hi;
        q  = (v + (64'sd1 <<< 29)) >>> 30;
        hi = (64'sd1 <<< (w - 1)) - 1;
        if (q > hi) begin
            q = hi;
        end else if (q < -hi - 1) begin
            q = -hi - 1;
        end
        return q;
    endfunction

    // Expected result word for one object word.
    function automatic result_t predict_object(input obj_t o);
        longint  pl, pt, vl, vt, eg, yr, dt;
        longint  ang, x, y, z, nx, c, s;
        longint  sum_long, sum_lat, rot_long, rot_lat;
        bit      flip;
        int      i;
        result_t r;
        pl = longint'($signed(o.pos_long));
        pt = longint'($signed(o.pos_lat));
        vl = longint'($signed(o.vel_long));
        vt = longint'($signed(o.vel_lat));
        eg = longint'($signed(o.ego_speed));
        yr = longint'($signed(o.yaw_rate));
        dt = longint'(o.time_step);

        // Angle in 2^-30 rad, wrapped into a half turn either way, then
        // folded into a quarter turn with the cosine and sine negated.
        ang = yr * dt * 4;
        for (i = 0; i < 4; i++) begin
            if (ang > ANG_PI) begin
                ang = ang - ANG_TWO_PI;
            end else if (ang < -ANG_PI) begin
                ang = ang + ANG_TWO_PI;
            end
        end
        flip = 1'b0;
        if (ang > ANG_HALF_PI) begin
            ang  = ang - ANG_PI;
            flip = 1'b1;
        end else if (ang < -ANG_HALF_PI) begin
            ang  = ang + ANG_PI;
            flip = 1'b1;
        end

        // Rotation-mode micro-rotations with floored shifts.
        x = ROT_GAIN;
        y = 0;
        z = ang;
        for (i = 0; i < STAGES; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - atan_table[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + atan_table[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;

        // Travel terms are speed times interval in 2^-23 m, scaled up to the
        // 2^-40 m of the rotated position products.
        sum_long = pl * c + pt * s - eg * dt * 131072 + vl * dt * 131072;
        sum_lat  = pt * c - pl * s + vt * dt * 131072;
        rot_long = vl * c + vt * s;
        rot_lat  = vt * c - vl * s;

        r.pred_pos_long = POS_W'(round_clamp(sum_long, POS_W));
        r.pred_pos_lat  = POS_W'(round_clamp(sum_lat, POS_W));
        r.pred_vel_long = VEL_W'(round_clamp(rot_long, VEL_W));
        r.pred_vel_lat  = VEL_W'(round_clamp(rot_lat, VEL_W));
        return r;
    endfunction

    function automatic obj_t make_object(input logic [31:0] pl, input logic [31:0] pt,
                                         input logic [31:0] vl, input logic [31:0] vt,
                                         input logic [31:0] eg, input logic [31:0] yr,
                                         input logic [31:0] dt);
        obj_t o;
        o.pos_long  = pl[POS_W-1:0];
        o.pos_lat   = pt[POS_W-1:0];
        o.vel_long  = vl[VEL_W-1:0];
        o.vel_lat   = vt[VEL_W-1:0];
        o.ego_speed = eg[VEL_W-1:0];
        o.yaw_rate  = yr[RATE_W-1:0];
        o.time_step = dt[DT_W-1:0];
        return o;
    endfunction

    // One field value: mostly uniform over the whole field, often near zero,
    // and sometimes one of the field's extremes.
    function automatic logic [31:0] random_field(input int w);
        logic [31:0] v;
        int          pick;
        pick = $urandom_range(0, 99);
        v    = $urandom;
        if (pick < 16) begin
            case ($urandom_range(0, 3))
                0:       v = (32'd1 << (w - 1)) - 32'd1;
                1:       v = 32'd1 << (w - 1);
                2:       v = '0;
                default: v = '1;
            endcase
        end else if (pick < 40) begin
            v = $urandom_range(0, 511) - 256;
        end
        return v;
    endfunction

    function automatic obj_t random_object();
        return make_object(random_field(POS_W), random_field(POS_W),
                           random_field(VEL_W), random_field(VEL_W),
                           random_field(VEL_W), random_field(RATE_W),
                           random_field(DT_W));
    endfunction

    // Idle gap in cycles: mostly none or short, now and then a long one.
    // During a quiet phase neither side idles.
    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet_phase) begin
            return 0;
        end else if (pick < 60) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 3);
        end else if (pick < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Sends one object word. tvalid is left high after the accepting edge so
    // that a back-to-back word never lowers and raises it in one time step.
    task automatic send_object(input obj_t o);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {o.time_step, o.yaw_rate, o.ego_speed, o.vel_lat, o.vel_long,
                     o.pos_lat, o.pos_long};
        do @(posedge aclk); while (!s_tready);
        pending_predictions.push_back(predict_object(o));
        objects_sent++;
    endtask

    // Field extremes, alternating bit patterns and a zero interval.
    task automatic test_field_extremes();
        send_object(make_object(0, 0, 0, 0, 0, 0, 0));
        send_object(make_object(524287, 524287, 32767, 32767, 32767, 32767, 65535));
        send_object(make_object(-524288, -524288, -32768, -32768, -32768, -32768, 0));
        send_object(make_object(32'hAAAAA, 32'h55555, 32'hAAAA, 32'h5555, 32'hAAAA,
                                32'h5555, 32'hAAAA));
        send_object(make_object(32'h55555, 32'hAAAAA, 32'h5555, 32'hAAAA, 32'h5555,
                                32'hAAAA, 32'h5555));
        send_object(make_object(100000, -200000, 5000, -3000, 7000, 32767, 0));
        send_object(make_object(524287, -524288, 32767, -32768, -32768, -32768, 0));
    endtask

    // Angles on both sides of the quarter turn and of the half turn, in both
    // directions, and the largest angles that need the full-turn wrap.
    task automatic test_angle_ranges();
        send_object(make_object(300000, -150000, 2560, -1280, 5120, 32767, 12868));
        send_object(make_object(300000, -150000, 2560, -1280, 5120, 32767, 12869));
        send_object(make_object(-250000, 180000, -3000, 4000, 2000, -32767, 12868));
        send_object(make_object(-250000, 180000, -3000, 4000, 2000, -32767, 12869));
        send_object(make_object(200000, 200000, 1000, 1000, 1000, 32767, 25736));
        send_object(make_object(200000, 200000, 1000, 1000, 1000, 32767, 25737));
        send_object(make_object(-200000, 90000, -1500, 700, 300, -32767, 25736));
        send_object(make_object(-200000, 90000, -1500, 700, 300, -32767, 25737));
        send_object(make_object(123456, -65432, 900, -900, 2500, 32767, 65535));
        send_object(make_object(-123456, 65432, -900, 900, -2500, -32768, 65535));
    endtask

    // Sums far past the position range in both directions, and a velocity
    // rotated by an eighth of a turn so that its larger component saturates.
    task automatic test_saturation();
        send_object(make_object(524287, 524287, 32767, 32767, -32768, 0, 65535));
        send_object(make_object(-524288, -524288, -32768, -32768, 32767, 0, 65535));
        send_object(make_object(0, 0, 32767, 32767, 0, -32768, 6434));
        send_object(make_object(0, 0, -32768, 32767, 0, 32767, 6434));
    endtask

    // The sender holds off until every result word of a burst has come.
    task automatic test_drain_pause();
        repeat (12) send_object(random_object());
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_predictions.size() != 0);
        repeat (12) send_object(random_object());
    endtask

    // Random objects, with a stretch in the middle where neither side idles.
    task automatic test_random_traffic();
        int n;
        for (n = 0; n < RANDOM_OBJECTS; n++) begin
            quiet_phase = (n >= 250 && n < 380);
            send_object(random_object());
        end
        quiet_phase = 1'b0;
    endtask

    // The result side accepts in bursts of random length between gaps.
    initial begin
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    // Every accepted result word is compared with the oldest prediction.
    // Values are read at the edge, before any register there updates.
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.pred_pos_long = m_tdata[19:0];
            got.pred_pos_lat  = m_tdata[39:20];
            got.pred_vel_long = m_tdata[55:40];
            got.pred_vel_lat  = m_tdata[71:56];
            if (pending_predictions.size() == 0) begin
                $error("result word with no prediction waiting: %h", m_tdata);
                mismatch_count++;
            end else begin
                want = pending_predictions.pop_front();
                results_checked++;
                if (got.pred_pos_long !== want.pred_pos_long) begin
                    $error("pred_pos_long: expected %0d, got %0d",
                           want.pred_pos_long, got.pred_pos_long);
                    mismatch_count++;
                end
                if (got.pred_pos_lat !== want.pred_pos_lat) begin
                    $error("pred_pos_lat: expected %0d, got %0d",
                           want.pred_pos_lat, got.pred_pos_lat);
                    mismatch_count++;
                end
                if (got.pred_vel_long !== want.pred_vel_long) begin
                    $error("pred_vel_long: expected %0d, got %0d",
                           want.pred_vel_long, got.pred_vel_long);
                    mismatch_count++;
                end
                if (got.pred_vel_lat !== want.pred_vel_lat) begin
                    $error("pred_vel_lat: expected %0d, got %0d",
                           want.pred_vel_lat, got.pred_vel_lat);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $error("timeout with %0d predictions outstanding", pending_predictions.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_field_extremes();
        test_angle_ranges();
        test_saturation();
        test_drain_pause();
        test_random_traffic();

        // Wait for the last result word, then a little past the pipeline
        // depth so that any extra word would still be caught.
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_predictions.size() != 0);
        repeat (LATENCY + 16) @(posedge aclk);

        $display("Sent %0d objects and checked %0d results: field extremes, angle wrap and",
                 objects_sent, results_checked);
        $display("fold, saturation, zero interval, a drain pause and random stalls on both sides.");
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
